[hw/rtl/rvn_pkg.sv]
// Shared types and constants of the RMS vector normaliser.
`timescale 1ns / 1ps
package rvn_pkg;

  // Fixed widths of the arithmetic.
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned SQ_W    = 31;
  localparam int unsigned SUM_W   = 39;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned EPS_W   = 16;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 2'd1;

  // Register reset values.
  localparam logic [LEN_W-1:0] VLEN_RESET = 9'd256;
  localparam logic [EPS_W-1:0] EPS_RESET  = 16'd1;

  // Controls shared by every lane.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } lane_ctrl_t;

  // Handshake with the reciprocal square root unit.
  typedef struct packed {
    logic                 done;
    logic [RECIP_W-1:0]   recip;
  } rsqrt_rsp_t;

endpackage

[hw/rtl/rvn_lane.sv]
// One lane: element store, square for the running sum and the scaling pipeline.
`timescale 1ns / 1ps
module rvn_lane #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned RW   = 6
) (
  input  logic                        clk_i,
  input  rvn_pkg::lane_ctrl_t         ctrl_i,
  input  logic [RW-1:0]               wr_row_i,
  input  logic [RW-1:0]               rd_row_i,
  input  logic                        active_i,
  input  logic signed [rvn_pkg::DATA_W-1:0] sample_i,
  input  logic signed [rvn_pkg::DATA_W-1:0] gain_i,
  input  logic [rvn_pkg::RECIP_W-1:0] recip_i,
  output logic [rvn_pkg::SQ_W-1:0]    square_o,
  output logic [rvn_pkg::DATA_W-1:0]  norm_o
);
  import rvn_pkg::*;

  logic [2*DATA_W-1:0] mem_q [ROWS];
  logic [2*DATA_W-1:0] rd_q;
  logic signed [2*DATA_W-1:0] sq_full;
  logic [SQ_W-1:0]     square_q;
  logic signed [DATA_W-1:0] x_s, g_s;
  logic [DATA_W-1:0]   ax, ag;
  logic [2*DATA_W-1:0] prod_full;
  logic [SQ_W-1:0]     prod_q;
  logic                neg_q, neg2_q;
  logic [SQ_W+RECIP_W-1:0] mag_full;
  logic [61:0]         mag_q;
  logic [24:0]         rnd;
  logic [16:0]         nsat;
  logic [16:0]         nneg;

  // Element store, one row per input request.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && active_i) begin
      mem_q[wr_row_i] <= {gain_i, sample_i};
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[rd_row_i];
    end
  end

  // Square of the incoming sample; lanes past the end contribute nothing.
  assign sq_full = sample_i * sample_i;
  always_ff @(posedge clk_i) begin
    square_q <= (ctrl_i.wr_en && active_i) ? sq_full[SQ_W-1:0] : '0;
  end
  assign square_o = square_q;

  // Magnitude product of sample and gain, then scaling by the reciprocal.
  assign x_s = $signed(rd_q[DATA_W-1:0]);
  assign g_s = $signed(rd_q[2*DATA_W-1:DATA_W]);
  assign ax  = x_s[DATA_W-1] ? DATA_W'(-x_s) : DATA_W'(x_s);
  assign ag  = g_s[DATA_W-1] ? DATA_W'(-g_s) : DATA_W'(g_s);
  assign prod_full = ax * ag;
  assign mag_full  = prod_q * recip_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[SQ_W-1:0];
    neg_q  <= x_s[DATA_W-1] ^ g_s[DATA_W-1];
    mag_q  <= mag_full[61:0];
    neg2_q <= neg_q;
  end

  // Round to nearest, ties away from zero, and saturate to Q8.8.
  always_comb begin
    rnd  = {1'b0, mag_q[61:38]} + 25'(mag_q[37]);
    nsat = (rnd > 25'd32768) ? 17'h08000 : rnd[16:0];
    nneg = 17'h10000 - nsat;
    if (neg2_q) begin
      norm_o = nneg[DATA_W-1:0];
    end else if (rnd > 25'd32767) begin
      norm_o = 16'h7FFF;
    end else begin
      norm_o = rnd[DATA_W-1:0];
    end
  end

endmodule

[hw/rtl/rvn_rsqrt.sv]
// Mean square and reciprocal square root by shared shift-and-subtract steps.
`timescale 1ns / 1ps
module rvn_rsqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rvn_pkg::SUM_W-1:0]   sum_i,
  input  logic [rvn_pkg::LEN_W-1:0]   len_i,
  input  logic [rvn_pkg::EPS_W-1:0]   eps_i,
  output rvn_pkg::rsqrt_rsp_t         rsp_o
);
  import rvn_pkg::*;

  typedef enum logic [4:0] {
    RS_IDLE  = 5'b00001,
    RS_MEAN  = 5'b00010,
    RS_DIV   = 5'b00100,
    RS_ROOT  = 5'b01000,
    RS_DONE  = 5'b10000
  } rs_state_e;

  rs_state_e   state_q, state_d;
  logic [64:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [30:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rad_q, rad_d;
  logic [31:0] root_q, root_d;
  logic [33:0] srem_q, srem_d;
  logic [32:0] dt;
  logic        dge;
  logic [35:0] st, trial;
  logic [30:0] mean;

  // One division step and one square root step.
  assign dt    = {rem_q, num_q[64]};
  assign dge   = dt >= {2'b00, den_q};
  assign st    = {srem_q, rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign mean  = num_q[30:0] + 31'(eps_i);

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    rad_d   = rad_q;
    root_d  = root_q;
    srem_d  = srem_q;
    case (state_q)
      RS_IDLE: begin
        if (start_i) begin
          num_d   = {26'd0, sum_i};
          den_d   = {22'd0, len_i};
          rem_d   = '0;
          cnt_d   = 7'd65;
          state_d = RS_MEAN;
        end
      end
      RS_MEAN, RS_DIV: begin
        if (cnt_q != 7'd0) begin
          rem_d = dge ? 32'(dt - {2'b00, den_q}) : dt[31:0];
          num_d = {num_q[63:0], dge};
          cnt_d = cnt_q - 7'd1;
        end else if (state_q == RS_MEAN) begin
          // Mean square known; saturate when it is zero or one.
          if (mean <= 31'd1) begin
            root_d  = '1;
            state_d = RS_DONE;
          end else begin
            num_d   = {1'b1, 64'd0};
            den_d   = mean;
            rem_d   = '0;
            cnt_d   = 7'd65;
            state_d = RS_DIV;
          end
        end else begin
          rad_d   = num_q[63:0];
          root_d  = '0;
          srem_d  = '0;
          cnt_d   = 7'd32;
          state_d = RS_ROOT;
        end
      end
      RS_ROOT: begin
        if (cnt_q != 7'd0) begin
          if (st >= trial) begin
            srem_d = 34'(st - trial);
            root_d = {root_q[30:0], 1'b1};
          end else begin
            srem_d = st[33:0];
            root_d = {root_q[30:0], 1'b0};
          end
          rad_d = {rad_q[61:0], 2'b00};
          cnt_d = cnt_q - 7'd1;
        end else begin
          state_d = RS_DONE;
        end
      end
      RS_DONE: begin
        state_d = RS_IDLE;
      end
      default: begin
        state_d = RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
  end

  assign rsp_o.done  = (state_q == RS_DONE);
  assign rsp_o.recip = root_q;

endmodule

[hw/rtl/rms_vector_normalizer.sv]
// Top level of the RMS vector normaliser.
`timescale 1ns / 1ps
// RMS normaliser: a vector of vector_length elements arrives LANE_COUNT
// lanes per request, one request per cycle while s_axis_tready is high,
// each lane held in its own row store while its square is added to an
// exact running sum. The request that completes the vector is followed by
// the flush and start states that settle the sum, then the reciprocal
// square root unit finds the mean, 2^64 / mean and the root, and hands
// over (a mean of zero or one skips the division and the root). Input
// stalls from then until the last group is taken. Each result group
// passes through the lane store read, the two multiplier stages and the
// result register, plus any wait for the sink; the next group is not read
// until this one is taken, and the last group carries tlast.
module rms_vector_normalizer #(
  parameter int unsigned MAX_LENGTH = 256,
  parameter int unsigned LANE_COUNT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Fields from bit 0 up: sample_0 .. sample_N, gain_0 .. gain_N.
  input  logic [LANE_COUNT*32-1:0]     s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0 up: norm_0 .. norm_N.
  output logic [LANE_COUNT*16-1:0]     m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rvn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);
  import rvn_pkg::*;

  localparam int unsigned ROWS = (MAX_LENGTH + LANE_COUNT - 1) / LANE_COUNT;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW   = $clog2(MAX_LENGTH + 1);
  localparam int unsigned EW   = $clog2(MAX_LENGTH + LANE_COUNT) + 1;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_FLUSH = 6'b000010,
    ST_START = 6'b000100,
    ST_RUN   = 6'b001000,
    ST_PIPE  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e               state_q;
  logic [LEN_W-1:0]     vlen_q;
  logic [EPS_W-1:0]     eps_q;
  logic [CW-1:0]        len;
  logic [CW-1:0]        cnt_q;
  logic [RW-1:0]        row_q, last_row_q, emit_row_q;
  logic [RW-1:0]        rd_row;
  logic [EW-1:0]        emit_base_q;
  logic [SUM_W-1:0]     acc_q, sq_sum;
  logic                 sq_vld_q;
  logic [RECIP_W-1:0]   recip_q;
  logic [1:0]           pipe_cnt_q;
  logic [LANE_COUNT-1:0] keep_q;
  logic [LANE_COUNT-1:0] active;
  logic                 final_q;
  logic [DATA_W-1:0]    out_q [LANE_COUNT];
  logic                 out_last_q;
  logic                 in_acc, out_acc, cfg_acc, complete;
  logic [DATA_W-1:0]    norm [LANE_COUNT];
  logic [SQ_W-1:0]      square [LANE_COUNT];
  lane_ctrl_t           lane_ctrl;
  rsqrt_rsp_t           rsq_rsp;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tlast  = out_last_q;

  // Length in force, with zero taken as one and large values clamped.
  always_comb begin
    if (vlen_q == '0) begin
      len = CW'(1);
    end else if (vlen_q > LEN_W'(MAX_LENGTH)) begin
      len = CW'(MAX_LENGTH);
    end else begin
      len = vlen_q[CW-1:0];
    end
  end

  // Lanes of the current request that fall inside the vector.
  always_comb begin
    for (int l = 0; l < LANE_COUNT; l++) begin
      active[l] = (EW'(cnt_q) + EW'(l)) < EW'(len);
    end
  end
  assign complete = (EW'(cnt_q) + EW'(LANE_COUNT)) >= EW'(len);

  assign lane_ctrl.wr_en = in_acc;
  assign lane_ctrl.rd_en = (state_q == ST_OUT && out_acc && !out_last_q) ||
                           (state_q == ST_RUN && rsq_rsp.done);

  // While a group is handed over, the read already fetches the next row.
  assign rd_row = (state_q == ST_OUT) ? emit_row_q + RW'(1) : emit_row_q;

  // Lane array.
  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    rvn_lane #(
      .ROWS (ROWS),
      .RW   (RW)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .wr_row_i (row_q),
      .rd_row_i (rd_row),
      .active_i (active[l]),
      .sample_i ($signed(s_axis_tdata[l*16 +: 16])),
      .gain_i   ($signed(s_axis_tdata[(LANE_COUNT+l)*16 +: 16])),
      .recip_i  (recip_q),
      .square_o (square[l]),
      .norm_o   (norm[l])
    );
    assign m_axis_tdata[l*16 +: 16] = out_q[l];
  end

  // Merge the lane squares into the running sum.
  always_comb begin
    sq_sum = acc_q;
    for (int l = 0; l < LANE_COUNT; l++) begin
      sq_sum = sq_sum + SUM_W'(square[l]);
    end
  end

  rvn_rsqrt u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .sum_i   (acc_q),
    .len_i   (LEN_W'(len)),
    .eps_i   (eps_q),
    .rsp_o   (rsq_rsp)
  );

  // Control and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      vlen_q      <= VLEN_RESET;
      eps_q       <= EPS_RESET;
      cnt_q       <= '0;
      row_q       <= '0;
      last_row_q  <= '0;
      emit_row_q  <= '0;
      emit_base_q <= '0;
      acc_q       <= '0;
      sq_vld_q    <= 1'b0;
      recip_q     <= '0;
      pipe_cnt_q  <= '0;
      final_q     <= 1'b0;
      out_last_q  <= 1'b0;
      keep_q      <= '0;
    end else begin
      sq_vld_q <= in_acc;
      if (sq_vld_q) begin
        acc_q <= sq_sum;
      end
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_VECTOR_LENGTH: begin
            vlen_q <= cfg_data_i[LEN_W-1:0];
            cnt_q  <= '0;
            row_q  <= '0;
            acc_q  <= '0;
          end
          CFG_EPSILON: eps_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (complete) begin
              cnt_q      <= '0;
              row_q      <= '0;
              last_row_q <= row_q;
              state_q    <= ST_FLUSH;
            end else begin
              cnt_q <= cnt_q + CW'(LANE_COUNT);
              row_q <= row_q + RW'(1);
            end
          end
        end
        ST_FLUSH: state_q <= ST_START;
        ST_START: begin
          acc_q   <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (rsq_rsp.done) begin
            recip_q     <= rsq_rsp.recip;
            emit_base_q <= '0;
            final_q     <= (last_row_q == '0);
            pipe_cnt_q  <= '0;
            state_q     <= ST_PIPE;
          end
        end
        ST_PIPE: begin
          if (pipe_cnt_q == 2'd2) begin
            out_last_q <= final_q;
            state_q    <= ST_OUT;
          end else begin
            pipe_cnt_q <= pipe_cnt_q + 2'd1;
          end
          for (int l = 0; l < LANE_COUNT; l++) begin
            keep_q[l] <= (emit_base_q + EW'(l)) < EW'(len);
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (out_last_q) begin
              emit_row_q <= '0;
              state_q    <= ST_LOAD;
            end else begin
              emit_row_q  <= emit_row_q + RW'(1);
              emit_base_q <= emit_base_q + EW'(LANE_COUNT);
              final_q     <= (emit_row_q + RW'(1)) == last_row_q;
              pipe_cnt_q  <= '0;
              state_q     <= ST_PIPE;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // Result register; lanes past the end read as zero.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PIPE && pipe_cnt_q == 2'd2) begin
      for (int l = 0; l < LANE_COUNT; l++) begin
        out_q[l] <= keep_q[l] ? norm[l] : '0;
      end
    end
  end

endmodule
